// ===== rtl/text_terminal_scroll_buffer_assert.svh =====
// Assertion macros for the text terminal scroll buffer.
`ifndef TEXT_TERMINAL_SCROLL_BUFFER_ASSERT_SVH
`define TEXT_TERMINAL_SCROLL_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tts_pkg.sv =====
// Shared types and constants for the text terminal scroll buffer.
package tts_pkg;

  localparam int unsigned MAX_COLS_DEF  = 64;
  localparam int unsigned MAX_LINES_DEF = 32;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned CFG_COLS_W  = 7;
  localparam int unsigned CFG_LINES_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SP  = 8'h20;

  localparam logic [CFG_COLS_W-1:0]  COLS_RESET  = 7'd64;
  localparam logic [CFG_LINES_W-1:0] LINES_RESET = 6'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_GOTO  = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS  = 2'd0,
    CFG_LINES = 2'd1,
    CFG_TRIM  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR_ALL,
    ST_IDLE,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_WRITE_CHAR,
    ST_READ_MOD,
    ST_READ_WAIT
  } state_e;

  typedef struct packed {
    logic [CFG_COLS_W-1:0]  cols;
    logic [CFG_LINES_W-1:0] lines;
    logic                   trim;
  } cfg_t;

endpackage

// ===== rtl/text_terminal_scroll_buffer.sv =====
// Top level of the text terminal scroll buffer: config registers, sequencer, result register.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tuser func; tdata char_code, row_index, col_index
//   m_axis   out  tdata read_char, one beat for each read item
//   cfg      in   register index and write data
//
// A write without scroll and a goto are handled in the idle state. A scroll clears the new line
// through the single write port of the character store, and the byte that caused it is stored
// afterwards when it was a wrap. A read runs the bit-serial row remainder unit and then the
// store's registered read.
// After reset the whole store is cleared, with s_axis_tready low; config writes are taken
// throughout.
// A read waits for a free result register; other items go ahead while a result beat waits.
module text_terminal_scroll_buffer #(
  parameter int unsigned MAX_COLS  = tts_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_LINES = tts_pkg::MAX_LINES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_code [7:0], row_index [12:8], col_index [18:13], zero [23:19]
  input  logic [tts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  logic [tts_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // read_char [7:0]
  output logic [tts_pkg::CHAR_W-1:0]     m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tts_pkg::cfg_t cfg_q, cfg_d;

  logic                       out_valid_q, out_valid_d;
  logic [tts_pkg::CHAR_W-1:0] out_data_q, out_data_d;
  logic                       out_free;
  logic                       res_valid;
  logic [tts_pkg::CHAR_W-1:0] res_data;
  logic                       read_beat;
  logic                       out_idle;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tts_pkg::cfg_reg_e'(cfg_index_i))
        tts_pkg::CFG_COLS:  cfg_d.cols  = cfg_data_i[tts_pkg::CFG_COLS_W-1:0];
        tts_pkg::CFG_LINES: cfg_d.lines = cfg_data_i[tts_pkg::CFG_LINES_W-1:0];
        tts_pkg::CFG_TRIM:  cfg_d.trim  = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols  <= tts_pkg::COLS_RESET;
      cfg_q.lines <= tts_pkg::LINES_RESET;
      cfg_q.trim  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tts_ctrl #(
    .MAX_COLS  (MAX_COLS),
    .MAX_LINES (MAX_LINES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser),
    .char_i      (s_axis_tdata[7:0]),
    .row_i       (s_axis_tdata[12:8]),
    .col_i       (s_axis_tdata[18:13]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  // Result register: a new result may load in the cycle the waiting beat leaves.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign read_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tts_pkg::FUNC_READ);
  assign out_idle  = !out_valid_q && !res_valid;

`include "text_terminal_scroll_buffer_assert.svh"

  `TTS_ASSERT_NOW(a_res_has_room, clk_i, rst_ni, res_valid, out_free, "result overwrote a beat")
  `TTS_ASSERT_NOW(a_res_not_idle, clk_i, rst_ni, res_valid, !s_axis_tready, "result in idle")
  `TTS_ASSERT_NEXT(a_read_blocks, clk_i, rst_ni, read_beat, !s_axis_tready, "input during read")
  `TTS_ASSERT_NEXT(a_out_from_res, clk_i, rst_ni, out_idle, !out_valid_q, "stray result beat")

endmodule

// ===== rtl/tts_mem.sv =====
// Character store: one write port and one read port with registered read data.
module tts_mem #(
  parameter int unsigned MAX_COLS  = tts_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_LINES = tts_pkg::MAX_LINES_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [$clog2(MAX_LINES)+$clog2(MAX_COLS)-1:0] waddr_i,
  input  logic [tts_pkg::CHAR_W-1:0]                     wdata_i,
  input  logic                                           re_i,
  input  logic [$clog2(MAX_LINES)+$clog2(MAX_COLS)-1:0] raddr_i,
  output logic [tts_pkg::CHAR_W-1:0]                     rdata_o
);

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned LW    = $clog2(MAX_LINES);
  localparam int unsigned AW    = LW + CW;
  localparam int unsigned DEPTH = MAX_LINES << CW;

  logic [tts_pkg::CHAR_W-1:0] mem_q [DEPTH];
  logic [tts_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tts_mod.sv =====
// Bit-serial remainder unit: dividend modulo the number of lines, one bit per cycle.
module tts_mod #(
  parameter int unsigned MAX_LINES = tts_pkg::MAX_LINES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(MAX_LINES + 32)-1:0] dividend_i,
  input  logic [$clog2(MAX_LINES + 1)-1:0]  divisor_i,
  output logic                              busy_o,
  output logic [$clog2(MAX_LINES)-1:0]      rem_o
);

  localparam int unsigned LW  = $clog2(MAX_LINES);
  localparam int unsigned NLW = $clog2(MAX_LINES + 1);
  localparam int unsigned SW  = $clog2(MAX_LINES + 32);
  localparam int unsigned CNW = $clog2(SW + 1);

  logic           busy_q, busy_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]  num_q, num_d;
  logic [NLW-1:0] rem_q, rem_d;
  logic [NLW-1:0] den_q, den_d;
  logic [NLW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    // The partial remainder stays below the divisor, so one extra bit holds the shifted value.
    trial  = {rem_q, num_q[SW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNW'(SW);
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = NLW'(trial - {1'b0, den_q});
      end else begin
        rem_d = NLW'(trial);
      end
      num_d  = num_q << 1;
      cnt_d  = cnt_q - CNW'(1);
      busy_d = (cnt_q != CNW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = LW'(rem_q);

endmodule

// ===== rtl/tts_ctrl.sv =====
// Cursor, scroll and read sequencer around the character store and the remainder unit.
module tts_ctrl #(
  parameter int unsigned MAX_COLS  = tts_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_LINES = tts_pkg::MAX_LINES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tts_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tts_pkg::FUNC_W-1:0] func_i,
  input  logic [tts_pkg::CHAR_W-1:0] char_i,
  input  logic [tts_pkg::ROW_W-1:0]  row_i,
  input  logic [tts_pkg::COL_W-1:0]  col_i,
  input  logic                       out_free_i,
  output logic                       res_valid_o,
  output logic [tts_pkg::CHAR_W-1:0] res_data_o
);

  localparam int unsigned CW       = $clog2(MAX_COLS);
  localparam int unsigned LW       = $clog2(MAX_LINES);
  localparam int unsigned AW       = LW + CW;
  localparam int unsigned CCW      = $clog2(MAX_COLS + 1);
  localparam int unsigned NLW      = $clog2(MAX_LINES + 1);
  localparam int unsigned SW       = $clog2(MAX_LINES + 32);
  localparam int unsigned CLR_LAST = (MAX_LINES << CW) - 1;

  tts_pkg::state_e state_q, state_d;

  logic [LW-1:0]              cl_q, cl_d;
  logic [LW-1:0]              scroll_q, scroll_d;
  logic [CCW-1:0]             cursor_q, cursor_d;
  logic                       wrap_q, wrap_d;
  logic                       trimming_q, trimming_d;
  logic                       pend_q, pend_d;
  logic [AW-1:0]              clr_cnt_q, clr_cnt_d;
  logic [tts_pkg::CHAR_W-1:0] char_q, char_d;
  logic [tts_pkg::COL_W-1:0]  col_q, col_d;
  logic                       oob_q, oob_d;

  logic [CCW-1:0] eff_cols;
  logic [NLW-1:0] eff_lines;
  tts_pkg::func_e func;
  logic           accept;
  logic           trim_skip;
  logic           is_nul;
  logic           is_nl;
  logic           need_wrap;
  logic           start_scroll;
  logic [CCW-1:0] cursor_inc;
  logic [LW-1:0]  next_line;
  logic [LW-1:0]  cl_goto;
  logic [CCW-1:0] cursor_goto;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tts_pkg::CHAR_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [tts_pkg::CHAR_W-1:0] rdata;

  logic          mod_start;
  logic [SW-1:0] mod_dividend;
  logic          mod_busy;
  logic [LW-1:0] mod_rem;

  tts_mem #(
    .MAX_COLS  (MAX_COLS),
    .MAX_LINES (MAX_LINES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tts_mod #(
    .MAX_LINES (MAX_LINES)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (eff_lines),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  // Effective sizes and item decode.
  always_comb begin
    if (cfg_i.cols == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(cfg_i.cols) > 32'(MAX_COLS)) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(cfg_i.cols);
    end
    if (cfg_i.lines == '0) begin
      eff_lines = NLW'(1);
    end else if (32'(cfg_i.lines) > 32'(MAX_LINES)) begin
      eff_lines = NLW'(MAX_LINES);
    end else begin
      eff_lines = NLW'(cfg_i.lines);
    end

    func      = tts_pkg::func_e'(func_i);
    accept    = in_valid_i && (state_q == tts_pkg::ST_IDLE);
    trim_skip = trimming_q && (char_i == tts_pkg::CHAR_SP || char_i == tts_pkg::CHAR_CR);
    is_nul    = (char_i == tts_pkg::CHAR_NUL);
    is_nl     = (char_i == tts_pkg::CHAR_NL);
    // A cursor left past the line end by a smaller column count wraps like a pending wrap.
    need_wrap = wrap_q || (cursor_q >= eff_cols);
    start_scroll = accept && (func == tts_pkg::FUNC_WRITE) && !trim_skip && !is_nul &&
                   (is_nl || need_wrap);

    cursor_inc = cursor_q + CCW'(1);
    next_line  = (32'(cl_q) + 32'd1 >= 32'(eff_lines)) ? '0 : cl_q + LW'(1);
    cl_goto    = (32'(row_i) >= 32'(eff_lines)) ? LW'(32'(eff_lines) - 32'd1) : LW'(row_i);
    cursor_goto = (32'(col_i) >= 32'(eff_cols)) ? CCW'(32'(eff_cols) - 32'd1) : CCW'(col_i);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tts_pkg::ST_CLEAR_ALL: begin
        if (clr_cnt_q == AW'(CLR_LAST)) state_d = tts_pkg::ST_IDLE;
      end
      tts_pkg::ST_IDLE: begin
        if (start_scroll) begin
          state_d = tts_pkg::ST_SCROLL;
        end else if (accept && func == tts_pkg::FUNC_READ) begin
          state_d = tts_pkg::ST_READ_MOD;
        end
      end
      tts_pkg::ST_SCROLL: begin
        if (clr_cnt_q[CW-1:0] == CW'(MAX_COLS - 1)) state_d = tts_pkg::ST_SCROLL_END;
      end
      tts_pkg::ST_SCROLL_END: begin
        if (!mod_busy) state_d = pend_q ? tts_pkg::ST_WRITE_CHAR : tts_pkg::ST_IDLE;
      end
      tts_pkg::ST_WRITE_CHAR: begin
        state_d = tts_pkg::ST_IDLE;
      end
      tts_pkg::ST_READ_MOD: begin
        if (!mod_busy) state_d = tts_pkg::ST_READ_WAIT;
      end
      tts_pkg::ST_READ_WAIT: begin
        if (out_free_i) state_d = tts_pkg::ST_IDLE;
      end
      default: begin
        state_d = tts_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    cl_d         = cl_q;
    scroll_d     = scroll_q;
    cursor_d     = cursor_q;
    wrap_d       = wrap_q;
    trimming_d   = trimming_q;
    pend_d       = pend_q;
    clr_cnt_d    = clr_cnt_q;
    char_d       = char_q;
    col_d        = col_q;
    oob_d        = oob_q;
    we           = 1'b0;
    waddr        = {cl_q, CW'(cursor_q)};
    wdata        = tts_pkg::CHAR_SP;
    re           = 1'b0;
    raddr        = {mod_rem, CW'(col_q)};
    mod_start    = 1'b0;
    mod_dividend = SW'(scroll_q) + SW'(1);
    res_valid_o  = 1'b0;
    res_data_o   = oob_q ? tts_pkg::CHAR_SP : rdata;
    in_ready_o   = (state_q == tts_pkg::ST_IDLE);

    unique case (state_q)
      tts_pkg::ST_CLEAR_ALL: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      tts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func)
            tts_pkg::FUNC_WRITE: begin
              if (trimming_q && !trim_skip) trimming_d = 1'b0;
              if (!trim_skip && !is_nul) begin
                if (is_nl || need_wrap) begin
                  // The scroll index update runs in the remainder unit during the line clear.
                  cl_d      = next_line;
                  cursor_d  = '0;
                  wrap_d    = 1'b0;
                  clr_cnt_d = '0;
                  mod_start = 1'b1;
                  pend_d    = !is_nl;
                  char_d    = char_i;
                  if (is_nl) trimming_d = cfg_i.trim;
                end else begin
                  we       = 1'b1;
                  wdata    = char_i;
                  cursor_d = cursor_inc;
                  wrap_d   = (cursor_inc >= eff_cols);
                end
              end
            end
            tts_pkg::FUNC_GOTO: begin
              cl_d     = cl_goto;
              cursor_d = cursor_goto;
              wrap_d   = 1'b0;
            end
            tts_pkg::FUNC_READ: begin
              mod_start    = 1'b1;
              mod_dividend = SW'(scroll_q) + SW'(1) + SW'(row_i);
              col_d        = col_i;
              oob_d        = (32'(col_i) >= 32'(MAX_COLS));
            end
            default: begin
            end
          endcase
        end
      end
      tts_pkg::ST_SCROLL: begin
        we        = 1'b1;
        waddr     = {cl_q, clr_cnt_q[CW-1:0]};
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      tts_pkg::ST_SCROLL_END: begin
        if (!mod_busy) scroll_d = mod_rem;
      end
      tts_pkg::ST_WRITE_CHAR: begin
        we       = 1'b1;
        wdata    = char_q;
        cursor_d = cursor_inc;
        wrap_d   = (cursor_inc >= eff_cols);
        pend_d   = 1'b0;
      end
      tts_pkg::ST_READ_MOD: begin
        if (!mod_busy) re = 1'b1;
      end
      tts_pkg::ST_READ_WAIT: begin
        if (out_free_i) res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tts_pkg::ST_CLEAR_ALL;
      cl_q       <= '0;
      scroll_q   <= '0;
      cursor_q   <= '0;
      wrap_q     <= 1'b0;
      trimming_q <= 1'b0;
      pend_q     <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      cl_q       <= cl_d;
      scroll_q   <= scroll_d;
      cursor_q   <= cursor_d;
      wrap_q     <= wrap_d;
      trimming_q <= trimming_d;
      pend_q     <= pend_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    col_q  <= col_d;
    oob_q  <= oob_d;
  end

endmodule

// ===== bench/tb_text_terminal_scroll_buffer.sv =====
// Self-checking testbench for the text terminal scroll buffer with a line-ring predictor.
module tb_text_terminal_scroll_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int unsigned MAX_COLS     = MAX_COLS_DEF;
  localparam int unsigned MAX_LINES    = MAX_LINES_DEF;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]     m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  text_terminal_scroll_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Predicted terminal state.
  logic [CHAR_W-1:0]      screen_cells [MAX_LINES*MAX_COLS];
  int unsigned            line_now;
  int unsigned            scroll_pos;
  int unsigned            column_now;
  bit                     wrap_due;
  bit                     trim_active;
  logic [CFG_COLS_W-1:0]  cfg_cols;
  logic [CFG_LINES_W-1:0] cfg_lines;
  logic                   cfg_trim;

  logic [CHAR_W-1:0] expected_chars [$];
  int unsigned       error_count;
  int unsigned       hold_request;
  bit                tx_idle_on;
  bit                rx_idle_on;

  function automatic int unsigned cols_limit();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLS) return MAX_COLS;
    return cfg_cols;
  endfunction

  function automatic int unsigned lines_limit();
    if (cfg_lines == 0) return 1;
    if (cfg_lines > MAX_LINES) return MAX_LINES;
    return cfg_lines;
  endfunction

  function automatic void advance_line();
    int unsigned n;
    n = lines_limit();
    // A current line left beyond a shrunken ring goes back to line 0.
    line_now   = (line_now + 1 >= n) ? 0 : line_now + 1;
    scroll_pos = (scroll_pos + 1) % n;
    column_now = 0;
    wrap_due   = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) screen_cells[line_now*MAX_COLS + i] = CHAR_SP;
  endfunction

  function automatic void store_byte(input logic [CHAR_W-1:0] ch);
    if (trim_active) begin
      if (ch == CHAR_SP || ch == CHAR_CR) return;
      trim_active = 1'b0;
    end
    if (ch == CHAR_NUL) return;
    if (ch == CHAR_NL) begin
      advance_line();
      if (cfg_trim) trim_active = 1'b1;
      return;
    end
    if (wrap_due || column_now >= cols_limit()) advance_line();
    if (column_now < MAX_COLS) screen_cells[line_now*MAX_COLS + column_now] = ch;
    column_now++;
    if (column_now >= cols_limit()) wrap_due = 1'b1;
  endfunction

  function automatic void predict_item(input logic [FUNC_W-1:0] kind,
                                       input logic [CHAR_W-1:0] ch,
                                       input logic [ROW_W-1:0]  row,
                                       input logic [COL_W-1:0]  col);
    int unsigned n;
    int unsigned c;
    int unsigned line;
    n = lines_limit();
    c = cols_limit();
    case (kind)
      FUNC_WRITE: begin
        store_byte(ch);
      end
      FUNC_GOTO: begin
        line_now   = (row >= n) ? n - 1 : row;
        column_now = (col >= c) ? c - 1 : col;
        wrap_due   = 1'b0;
      end
      FUNC_READ: begin
        line = (scroll_pos + 1 + row) % n;
        if (col < MAX_COLS) expected_chars.push_back(screen_cells[line*MAX_COLS + col]);
        else expected_chars.push_back(CHAR_SP);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W-CHAR_W-ROW_W-COL_W){1'b0}}, col, row, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, ch, row, col);
  endtask

  task automatic write_char(input logic [CHAR_W-1:0] ch);
    send_item(FUNC_WRITE, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic goto_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_item(FUNC_GOTO, CHAR_W'($urandom), row, col);
  endtask

  task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_item(FUNC_READ, CHAR_W'($urandom), row, col);
  endtask

  // Waits for every pending read beat, then lets any scroll still in progress finish.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] lines,
                                input logic [CFG_DATA_W-1:0] trim);
    cfg_reg_e idx;
    logic [CFG_DATA_W-1:0] value;
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      idx   = (i == 0) ? CFG_COLS : (i == 1) ? CFG_LINES : CFG_TRIM;
      value = (i == 0) ? cols : (i == 1) ? lines : trim;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= value;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_COLS:  cfg_cols  = value[CFG_COLS_W-1:0];
        CFG_LINES: cfg_lines = value[CFG_LINES_W-1:0];
        default:   cfg_trim  = value[0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned r;
    int unsigned k;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    r   = $urandom_range(0, 99);
    ch  = CHAR_W'($urandom);
    row = ROW_W'($urandom);
    col = COL_W'($urandom);
    if (r < 55) begin
      k = $urandom_range(0, 19);
      if (k < 2) ch = CHAR_NL;
      else if (k < 4) ch = CHAR_SP;
      else if (k == 4) ch = CHAR_CR;
      else if (k == 5) ch = CHAR_NUL;
      else if (k < 19) ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
      send_item(FUNC_WRITE, ch, row, col);
    end else if (r < 63) begin
      send_item(FUNC_GOTO, ch, row, col);
    end else if (r < 95) begin
      // Most reads land on the part of the display that is in use.
      if ($urandom_range(0, 4) != 0) begin
        row = ROW_W'($urandom_range(0, lines_limit() - 1));
        col = COL_W'($urandom_range(0, cols_limit() - 1));
      end
      send_item(FUNC_READ, ch, row, col);
    end else begin
      send_item(FUNC_NONE, ch, row, col);
    end
  endtask

  task automatic test_plain_text();
    apply_settings(7'd64, 7'd32, 7'd0);
    write_char("A");
    write_char(8'hFF);
    write_char(8'h01);
    write_char(CHAR_NUL);
    write_char(CHAR_CR);
    write_char(CHAR_NL);
    read_cell(5'd30, 6'd0);
    read_cell(5'd30, 6'd3);
    read_cell(5'd31, 6'd63);
    goto_cell(5'd31, 6'd63);
    write_char("Z");
    // The line is full, so this byte scrolls into line 0 first.
    write_char("Y");
    send_item(FUNC_NONE, 8'hFF, 5'd31, 6'd63);
    read_cell(5'd28, 6'd63);
    read_cell(5'd29, 6'd0);
    goto_cell(5'd20, 6'd40);
    write_char("m");
  endtask

  task automatic test_trim_and_clamp();
    // Shrinking the sizes leaves the cursor and the line outside the new ring.
    apply_settings(7'd5, 7'd3, 7'd1);
    write_char("n");
    goto_cell(5'd31, 6'd63);
    write_char("x");
    write_char(CHAR_NL);
    write_char(CHAR_SP);
    write_char(CHAR_CR);
    write_char("q");
    write_char(CHAR_NL);
    write_char(CHAR_NUL);
    write_char(CHAR_SP);
    read_cell(5'd0, 6'd4);
    read_cell(5'd31, 6'd0);
  endtask

  task automatic test_backpressure();
    apply_settings(7'd16, 7'd6, 7'd0);
    tx_idle_on   = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 50; i++) begin
      if ($urandom_range(0, 9) < 7) read_cell(ROW_W'($urandom), COL_W'($urandom));
      else write_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
    end
  endtask

  task automatic test_random_settings();
    int unsigned cols_tab [6] = '{64, 1, 0, 127, 8, 3};
    int unsigned lines_tab[6] = '{32, 1, 0, 127, 4, 2};
    int unsigned trim_tab [6] = '{0, 1, 0, 1, 1, 0};
    for (int p = 0; p < 14; p++) begin
      if (p < 6) begin
        apply_settings(CFG_DATA_W'(cols_tab[p]), CFG_DATA_W'(lines_tab[p]),
                       CFG_DATA_W'(trim_tab[p]));
      end else begin
        apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      end
      tx_idle_on = (p % 4 == 0) || (p % 4 == 1);
      rx_idle_on = (p % 4 == 0) || (p % 4 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end
  endtask

  always @(posedge clk_i) begin : result_check
    logic [CHAR_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("read_char %02h with no read pending", m_axis_tdata));
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("read_char %02h, expected %02h", m_axis_tdata, want));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = rx_idle_on ? pick_gap() : 0;
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("tb_text_terminal_scroll_buffer: done, errors");
    $finish;
  end

  initial begin
    foreach (screen_cells[i]) screen_cells[i] = CHAR_SP;
    line_now     = 0;
    scroll_pos   = 0;
    column_now   = 0;
    wrap_due     = 1'b0;
    trim_active  = 1'b0;
    cfg_cols     = COLS_RESET;
    cfg_lines    = LINES_RESET;
    cfg_trim     = 1'b0;
    error_count  = 0;
    hold_request = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_text();
    test_trim_and_clamp();
    test_backpressure();
    test_random_settings();

    wait_idle();
    if (error_count == 0) begin
      $display("tb_text_terminal_scroll_buffer: done, clean");
    end else begin
      $display("tb_text_terminal_scroll_buffer: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_mem.sv
rtl/tts_mod.sv
rtl/tts_ctrl.sv
rtl/text_terminal_scroll_buffer.sv
bench/tb_text_terminal_scroll_buffer.sv
